### rtl/mss_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mss_pkg
// Shared constants and types for the multi-stack shared store.
// ---------------------------------------------------------------------------
package mss_pkg;

    localparam int NUM_STACKS_DEF  = 4;
    localparam int NUM_ENTRIES_DEF = 64;

    localparam int STACK_ID_W = 2;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

endpackage

### rtl/mss_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mss_req_if
// Request channel: push or pop beats with valid/ready handshake.
// ---------------------------------------------------------------------------
interface mss_req_if;
    import mss_pkg::*;

    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic [STACK_ID_W-1:0]        stack_id;
    logic signed [VALUE_W-1:0]    push_value;

    modport source (output valid, output req_type, output stack_id, output push_value,
                    input ready);
    modport sink   (input valid, input req_type, input stack_id, input push_value,
                    output ready);
endinterface

### rtl/mss_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mss_rsp_if
// Response channel: status and popped value per beat, valid/ready handshake.
// ---------------------------------------------------------------------------
interface mss_rsp_if;
    import mss_pkg::*;

    logic                         valid;
    logic                         ready;
    status_t                      status;
    logic signed [VALUE_W-1:0]    pop_value;

    modport source (output valid, output status, output pop_value, input ready);
    modport sink   (input valid, input status, input pop_value, output ready);
endinterface

### rtl/mss_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mss_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/multi_stack_shared_store_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_stack_shared_store_top
// Several LIFO stacks sharing one entry store, free list threaded via links.
// ---------------------------------------------------------------------------
// Flow: the request beat is accepted in S_IDLE; S_HEAD uses the head-pointer
//   RAM read, S_LINK the dependent entry RAM read (both registered reads),
//   and the write-back and response register update happen in S_LINK once
//   the response channel is free. No new beat is taken until back in S_IDLE.
// Reset: all stacks empty, free list starts at entry 0; no clearing pass,
//   untouched entries link to the next entry through a fill mark.
// ---------------------------------------------------------------------------
module multi_stack_shared_store_top
    import mss_pkg::*;
#(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    mss_req_if.sink     req,
    mss_rsp_if.source   rsp
);

    localparam int PW = $clog2(NUM_ENTRIES + 1);
    localparam int AW = $clog2(NUM_ENTRIES);
    localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int EW = PW + VALUE_W;

    localparam logic [PW-1:0] NULL_PTR = PW'(NUM_ENTRIES);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_HEAD = 2'd1;
    localparam logic [1:0] S_LINK = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic                      req_type_reg;
    logic [SW-1:0]             sid_reg;
    logic                      sid_ok_reg;
    logic [VALUE_W-1:0]        push_value_reg;
    logic [PW-1:0]             head_reg;
    logic [PW-1:0]             ptr_reg;
    logic [PW-1:0]             free_head_reg;
    logic [PW-1:0]             fill_reg;
    logic [NUM_STACKS-1:0]     head_vld_reg;
    logic                      rsp_valid_reg;
    status_t                   status_reg;
    logic [VALUE_W-1:0]        pop_value_reg;

    logic                      accept;
    logic                      commit;
    logic [PW-1:0]             head_cur;
    logic [PW-1:0]             ptr_sel;
    logic [PW-1:0]             link_raw;
    logic [PW-1:0]             link_cur;
    logic [VALUE_W-1:0]        val_cur;
    logic                      ptr_ok;
    logic                      push_done;
    logic                      pop_done;

    logic                      head_we;
    logic [PW-1:0]             head_wdata;
    logic [PW-1:0]             head_rdata;
    logic                      ent_we;
    logic [AW-1:0]             ent_raddr;
    logic [EW-1:0]             ent_wdata;
    logic [EW-1:0]             ent_rdata;

    assign req.ready  = (state_reg == S_IDLE);
    assign accept     = req.valid && req.ready;
    assign commit     = (state_reg == S_LINK) && (!rsp_valid_reg || rsp.ready);

    assign head_cur   = head_vld_reg[sid_reg] ? head_rdata : NULL_PTR;
    assign ptr_sel    = (req_type_reg == REQ_POP) ? head_cur : free_head_reg;
    assign ent_raddr  = (state_reg == S_HEAD) ? ptr_sel[AW-1:0] : ptr_reg[AW-1:0];

    assign link_raw   = ent_rdata[VALUE_W +: PW];
    assign val_cur    = ent_rdata[VALUE_W-1:0];
    // untouched entries still hold their reset link to the next entry
    assign link_cur   = (ptr_reg >= fill_reg) ? PW'(ptr_reg + PW'(1)) : link_raw;

    assign ptr_ok     = sid_ok_reg && (ptr_reg < NULL_PTR);
    assign push_done  = commit && ptr_ok && (req_type_reg == REQ_PUSH);
    assign pop_done   = commit && ptr_ok && (req_type_reg == REQ_POP);

    assign head_we    = push_done || pop_done;
    assign head_wdata = push_done ? ptr_reg : link_cur;
    assign ent_we     = head_we;
    assign ent_wdata  = push_done ? {head_reg, push_value_reg} : {free_head_reg, val_cur};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_LINK;
            end
            S_LINK:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            fill_reg      <= '0;
            head_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (push_done)
            begin
                free_head_reg <= link_cur;
                if (ptr_reg >= fill_reg)
                begin
                    fill_reg <= PW'(fill_reg + PW'(1));
                end
            end
            else if (pop_done)
            begin
                free_head_reg <= ptr_reg;
            end
            if (head_we)
            begin
                head_vld_reg[sid_reg] <= 1'b1;
            end
            if (commit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_type_reg   <= req.req_type;
            sid_reg        <= SW'(req.stack_id);
            sid_ok_reg     <= (int'(req.stack_id) < NUM_STACKS);
            push_value_reg <= req.push_value;
        end
        if (state_reg == S_HEAD)
        begin
            head_reg <= head_cur;
            ptr_reg  <= ptr_sel;
        end
        if (commit)
        begin
            if (ptr_ok)
            begin
                status_reg <= ST_DONE;
            end
            else if (req_type_reg == REQ_PUSH)
            begin
                status_reg <= ST_FULL;
            end
            else
            begin
                status_reg <= ST_EMPTY;
            end
            pop_value_reg <= pop_done ? val_cur : '0;
        end
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.status    = status_reg;
    assign rsp.pop_value = pop_value_reg;

    mss_ram #(
        .WIDTH (PW),
        .DEPTH (NUM_STACKS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (sid_reg),
        .wdata (head_wdata),
        .raddr (SW'(req.stack_id)),
        .rdata (head_rdata)
    );

    mss_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_ENTRIES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ptr_reg[AW-1:0]),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

endmodule
